/* hw/rtl/eia_pkg.sv */
// Package for the entity identifier allocator.
// Holds the operation and status codes and the fixed port widths; no dependencies.
`default_nettype none

package eia_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned ENTITY_W  = 16;
  localparam int unsigned SIG_IN_W  = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ENT_OUT_W = 10;
  localparam int unsigned SIG_OUT_W = 32;
  localparam int unsigned LIVE_W    = 11;

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_SET    = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/eia_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for every store of the identifier allocator; no dependencies.
`default_nettype none

module eia_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/entity_id_allocator.sv */
// Entity identifier allocator: FIFO free list, active bit and signature per identifier.
// Depends on eia_pkg and eia_ram.
//
// A command word is taken at a rising edge where start_i is high and busy_o is low.
// op_i selects create, delete, set signature, get signature, query active or clear;
// entity_i and signature_in_i are the operands. The command's memories are read in
// the accept cycle, the operation is executed and written back in the next cycle,
// and the result word appears in the cycle after that, marked by done_o for exactly
// one cycle. The receiver cannot stall; every result is taken when shown.
// A command takes one memory read, then one read-modify-write step.
// busy_o is high during execution, so a new command can be accepted in the same
// cycle as the previous result is shown.
// After reset, and after every clear command, the block sweeps both memories,
// one entry a cycle, restoring the free list to 0..MAX_IDS-1 and zeroing
// all active bits and signatures; busy_o stays high meanwhile.
// live_count_o reports the number of identifiers in use after the operation.
`default_nettype none

module entity_id_allocator #(
  parameter int unsigned MAX_IDS  = 1024,
  parameter int unsigned SIG_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output      logic                             busy_o,
  input  wire logic [eia_pkg::OP_W-1:0]         op_i,
  input  wire logic [eia_pkg::ENTITY_W-1:0]     entity_i,
  input  wire logic [eia_pkg::SIG_IN_W-1:0]     signature_in_i,
  output      logic                             done_o,
  output      logic [eia_pkg::STATUS_W-1:0]     status_o,
  output      logic [eia_pkg::ENT_OUT_W-1:0]    entity_out_o,
  output      logic [eia_pkg::SIG_OUT_W-1:0]    signature_out_o,
  output      logic                             is_active_o,
  output      logic [eia_pkg::LIVE_W-1:0]       live_count_o
);

  localparam int unsigned ID_W  = $clog2(MAX_IDS);
  localparam int unsigned CNT_W = $clog2(MAX_IDS + 1);
  localparam int unsigned ENT_W = SIG_BITS + 1;
  localparam logic [ID_W-1:0]  LAST_ID   = ID_W'(MAX_IDS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_IDS);
  localparam logic [eia_pkg::ENTITY_W:0] RANGE_LIM = (eia_pkg::ENTITY_W + 1)'(MAX_IDS);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [ID_W-1:0]                 sweep_q, sweep_d;
  logic [ID_W-1:0]                 head_q, head_d;
  logic [ID_W-1:0]                 tail_q, tail_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [eia_pkg::OP_W-1:0]        op_q;
  logic [eia_pkg::ENTITY_W-1:0]    ent_q;
  logic [SIG_BITS-1:0]             sig_q;
  logic                            in_range_q;

  logic                            done_q, done_d;
  logic [eia_pkg::STATUS_W-1:0]    status_q, status_d;
  logic [eia_pkg::ENT_OUT_W-1:0]   eout_q, eout_d;
  logic [eia_pkg::SIG_OUT_W-1:0]   sout_q, sout_d;
  logic                            act_q, act_d;

  logic                            accept;
  logic                            in_range;
  logic                            ring_we;
  logic [ID_W-1:0]                 ring_waddr, ring_wdata, ring_rdata;
  logic                            ent_we;
  logic [ID_W-1:0]                 ent_waddr;
  logic [ENT_W-1:0]                ent_wdata, ent_rdata;
  logic                            ent_active;
  logic [ID_W-1:0]                 ent_idx;
  logic [eia_pkg::ENTITY_W-1:0]    new_id_wide;

  assign accept     = start_i && (state_q == S_IDLE);
  assign busy_o     = (state_q != S_IDLE);
  assign in_range   = ({1'b0, entity_i} < RANGE_LIM);
  assign ent_idx    = ent_q[ID_W-1:0];
  assign ent_active = in_range_q && ent_rdata[SIG_BITS];
  assign new_id_wide = eia_pkg::ENTITY_W'(ring_rdata);

  eia_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_IDS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  eia_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_IDS)
  ) u_entry (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (entity_i[ID_W-1:0]),
    .rdata_o (ent_rdata)
  );

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    ring_we    = 1'b0;
    ring_waddr = tail_q;
    ring_wdata = ent_idx;
    ent_we     = 1'b0;
    ent_waddr  = ent_idx;
    ent_wdata  = '0;
    done_d     = 1'b0;
    status_d   = eia_pkg::ST_OK;
    eout_d     = ent_q[eia_pkg::ENT_OUT_W-1:0];
    sout_d     = '0;
    act_d      = 1'b0;

    unique case (state_q)
      S_INIT: begin
        ring_we    = 1'b1;
        ring_waddr = sweep_q;
        ring_wdata = sweep_q;
        ent_we     = 1'b1;
        ent_waddr  = sweep_q;
        ent_wdata  = '0;
        sweep_d    = sweep_q + 1'b1;
        if (sweep_q == LAST_ID) begin
          sweep_d = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        case (op_q)
          eia_pkg::OP_CREATE: begin
            if (count_q != FULL_CNT) begin
              head_d    = (head_q == LAST_ID) ? '0 : head_q + 1'b1;
              count_d   = count_q + 1'b1;
              ent_we    = 1'b1;
              ent_waddr = ring_rdata;
              ent_wdata = {1'b1, {SIG_BITS{1'b0}}};
              eout_d    = new_id_wide[eia_pkg::ENT_OUT_W-1:0];
              act_d     = 1'b1;
            end else begin
              status_d = eia_pkg::ST_NO_FREE;
            end
          end
          eia_pkg::OP_DELETE: begin
            if (ent_active) begin
              ring_we   = 1'b1;
              tail_d    = (tail_q == LAST_ID) ? '0 : tail_q + 1'b1;
              count_d   = count_q - 1'b1;
              ent_we    = 1'b1;
              ent_wdata = '0;
            end else begin
              status_d = eia_pkg::ST_NOT_ACTIVE;
            end
          end
          eia_pkg::OP_SET: begin
            if (ent_active) begin
              ent_we    = 1'b1;
              ent_wdata = {1'b1, sig_q};
              act_d     = 1'b1;
            end else begin
              status_d = eia_pkg::ST_NOT_ACTIVE;
            end
          end
          eia_pkg::OP_GET: begin
            if (ent_active) begin
              sout_d = eia_pkg::SIG_OUT_W'(ent_rdata[SIG_BITS-1:0]);
              act_d  = 1'b1;
            end else begin
              status_d = eia_pkg::ST_NOT_ACTIVE;
            end
          end
          eia_pkg::OP_CLEAR: begin
            head_d  = '0;
            tail_d  = '0;
            count_d = '0;
            sweep_d = '0;
            state_d = S_INIT;
          end
          default: begin
            act_d = ent_active;
          end
        endcase
      end
      default: begin
        state_d = S_INIT;
        sweep_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      sweep_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_i;
      ent_q      <= entity_i;
      sig_q      <= SIG_BITS'(signature_in_i);
      in_range_q <= in_range;
    end
    if (done_d) begin
      status_q <= status_d;
      eout_q   <= eout_d;
      sout_q   <= sout_d;
      act_q    <= act_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign entity_out_o    = eout_q;
  assign signature_out_o = sout_q;
  assign is_active_o     = act_q;
  assign live_count_o    = eia_pkg::LIVE_W'(count_q);

endmodule

`default_nettype wire

/* tb/sv/tb_entity_id_allocator.sv */
// Self-checking testbench for entity_id_allocator: drives command words through the
// start/busy handshake and checks every result word against a behavioral allocator.
// Depends on eia_pkg and the allocator RTL only.
module tb_entity_id_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import eia_pkg::*;

  localparam int unsigned MAX_IDS  = 1024;
  localparam int unsigned SIG_BITS = 32;
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ENT_OUT_W-1:0] entity;
    logic [SIG_OUT_W-1:0] signature;
    logic                 active;
    logic [LIVE_W-1:0]    live;
  } alloc_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [OP_W-1:0]      op_i;
  logic [ENTITY_W-1:0]  entity_i;
  logic [SIG_IN_W-1:0]  signature_in_i;
  logic                 done_o;
  logic [STATUS_W-1:0]  status_o;
  logic [ENT_OUT_W-1:0] entity_out_o;
  logic [SIG_OUT_W-1:0] signature_out_o;
  logic                 is_active_o;
  logic [LIVE_W-1:0]    live_count_o;

  logic [ENT_OUT_W-1:0] free_ring [MAX_IDS];
  logic                 id_live [MAX_IDS];
  logic [SIG_OUT_W-1:0] id_signature [MAX_IDS];
  int                   ring_head;
  int                   ring_tail;
  int                   live_ids;

  alloc_word_t pending_words[$];
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          full_hits = 0;
  int          clears_sent = 0;
  bit          quiet_stretch = 1'b0;

  entity_id_allocator #(
    .MAX_IDS (MAX_IDS),
    .SIG_BITS(SIG_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .entity_i       (entity_i),
    .signature_in_i (signature_in_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .entity_out_o   (entity_out_o),
    .signature_out_o(signature_out_o),
    .is_active_o    (is_active_o),
    .live_count_o   (live_count_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void restore_free_list();
    for (int i = 0; i < MAX_IDS; i++) begin
      free_ring[i]    = ENT_OUT_W'(i);
      id_live[i]      = 1'b0;
      id_signature[i] = '0;
    end
    ring_head = 0;
    ring_tail = 0;
    live_ids  = 0;
  endfunction

  function automatic int ring_next(int p);
    return (p == MAX_IDS - 1) ? 0 : p + 1;
  endfunction

  function automatic alloc_word_t next_alloc_word(logic [OP_W-1:0] op,
                                                  logic [ENTITY_W-1:0] ent,
                                                  logic [SIG_IN_W-1:0] sig);
    alloc_word_t w;
    logic        hit;
    int          idx;
    idx         = int'(ent);
    hit         = (idx < MAX_IDS) && id_live[idx % MAX_IDS];
    w.status    = ST_OK;
    w.entity    = ent[ENT_OUT_W-1:0];
    w.signature = '0;
    w.active    = 1'b0;
    case (op)
      OP_CREATE: begin
        if (live_ids < MAX_IDS) begin
          w.entity          = free_ring[ring_head];
          id_live[w.entity] = 1'b1;
          ring_head         = ring_next(ring_head);
          live_ids++;
          w.active          = 1'b1;
        end else begin
          w.status = ST_NO_FREE;
        end
      end
      OP_DELETE: begin
        if (hit) begin
          free_ring[ring_tail] = ENT_OUT_W'(idx);
          ring_tail            = ring_next(ring_tail);
          id_live[idx]         = 1'b0;
          id_signature[idx]    = '0;
          live_ids--;
        end else begin
          w.status = ST_NOT_ACTIVE;
        end
      end
      OP_SET: begin
        if (hit) begin
          id_signature[idx] = sig;
          w.active          = 1'b1;
        end else begin
          w.status = ST_NOT_ACTIVE;
        end
      end
      OP_GET: begin
        if (hit) begin
          w.signature = id_signature[idx];
          w.active    = 1'b1;
        end else begin
          w.status = ST_NOT_ACTIVE;
        end
      end
      OP_CLEAR: restore_free_list();
      default: w.active = hit;
    endcase
    w.live = LIVE_W'(live_ids);
    return w;
  endfunction

  function automatic int find_live_id(int from);
    int idx;
    for (int k = 0; k < MAX_IDS; k++) begin
      idx = (from + k) % MAX_IDS;
      if (id_live[idx]) return idx;
    end
    return -1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic pause();
    int n;
    n = quiet_stretch ? 0 : gap_len();
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_word(input logic [OP_W-1:0] op, input logic [ENTITY_W-1:0] ent,
                           input logic [SIG_IN_W-1:0] sig);
    alloc_word_t w;
    start_i        <= 1'b1;
    op_i           <= op;
    entity_i       <= ent;
    signature_in_i <= sig;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    w = next_alloc_word(op, ent, sig);
    if (w.status == ST_NO_FREE) full_hits++;
    if (op == OP_CLEAR) clears_sent++;
    pending_words.push_back(w);
    words_sent++;
    pause();
  endtask

  function automatic logic [ENTITY_W-1:0] pick_entity();
    int r;
    int id;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      id = find_live_id($urandom_range(0, MAX_IDS - 1));
      if (id >= 0) return ENTITY_W'(id);
    end
    if (r < 90) return ENTITY_W'($urandom_range(0, MAX_IDS - 1));
    return ENTITY_W'($urandom);
  endfunction

  function automatic logic [SIG_IN_W-1:0] pick_signature();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin : check_result
    alloc_word_t w;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_words.size() == 0) begin
        $error("result word with no command outstanding");
        mismatch_count++;
      end else begin
        w = pending_words.pop_front();
        words_checked++;
        if (status_o !== w.status) begin
          $error("status: expected %0d, actual %0d", w.status, status_o);
          mismatch_count++;
        end
        if (entity_out_o !== w.entity) begin
          $error("entity_out: expected %0d, actual %0d", w.entity, entity_out_o);
          mismatch_count++;
        end
        if (signature_out_o !== w.signature) begin
          $error("signature_out: expected %h, actual %h", w.signature, signature_out_o);
          mismatch_count++;
        end
        if (is_active_o !== w.active) begin
          $error("is_active: expected %0d, actual %0d", w.active, is_active_o);
          mismatch_count++;
        end
        if (live_count_o !== w.live) begin
          $error("live_count: expected %0d, actual %0d", w.live, live_count_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_word(OP_CREATE, 16'hFFFF, 32'h0);
    send_word(OP_CREATE, 16'h0000, 32'hFFFF_FFFF);
    send_word(OP_SET, 16'd0, 32'hFFFF_FFFF);
    send_word(OP_GET, 16'd0, 32'h0);
    send_word(OP_SET, 16'd1, 32'h0);
    send_word(OP_GET, 16'd1, 32'hFFFF_FFFF);
    send_word(OP_QUERY, 16'd0, 32'h0);
    send_word(OP_QUERY, 16'd2, 32'h0);
    send_word(OP_GET, 16'd2, 32'h0);
    send_word(OP_SET, 16'd2, 32'h1234_5678);
    send_word(OP_DELETE, 16'd2, 32'h0);
    send_word(OP_QUERY, 16'd1024, 32'h0);
    send_word(OP_GET, 16'd1024, 32'h0);
    send_word(OP_SET, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_DELETE, 16'hFFFF, 32'h0);
    send_word(OP_QUERY, 16'hFFFF, 32'h0);
    send_word(OP_SPARE6, 16'd0, 32'hFFFF_FFFF);
    send_word(OP_SPARE7, 16'd1, 32'h0);
    send_word(OP_DELETE, 16'd0, 32'h0);
    send_word(OP_DELETE, 16'd0, 32'h0);
    send_word(OP_GET, 16'd0, 32'h0);
    send_word(OP_CREATE, 16'd0, 32'h0);
    send_word(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_QUERY, 16'd1, 32'h0);
    send_word(OP_CREATE, 16'd0, 32'h0);
  endtask

  task automatic test_exhaust();
    int id;
    quiet_stretch = 1'b1;
    while (live_ids < MAX_IDS) send_word(OP_CREATE, ENTITY_W'($urandom), $urandom);
    quiet_stretch = 1'b0;
    repeat (3) send_word(OP_CREATE, ENTITY_W'($urandom), $urandom);
    repeat (40) begin
      id = find_live_id($urandom_range(0, MAX_IDS - 1));
      send_word(OP_SET, ENTITY_W'(id), pick_signature());
      send_word(OP_DELETE, ENTITY_W'(id), $urandom);
    end
    repeat (50) send_word(OP_CREATE, ENTITY_W'($urandom), $urandom);
  endtask

  task automatic test_random(input int count);
    int r;
    logic [OP_W-1:0] op;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 199);
      if (r < 60)       op = OP_CREATE;
      else if (r < 100) op = OP_DELETE;
      else if (r < 130) op = OP_SET;
      else if (r < 160) op = OP_GET;
      else if (r < 185) op = OP_QUERY;
      else if (r < 191) op = OP_SPARE6;
      else if (r < 197) op = OP_SPARE7;
      else              op = OP_CLEAR;
      send_word(op, pick_entity(), pick_signature());
    end
    quiet_stretch = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    op_i           = OP_QUERY;
    entity_i       = '0;
    signature_in_i = '0;
    restore_free_list();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_exhaust();
    test_random(200);
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $error("%0d result words never arrived", pending_words.size());
      mismatch_count++;
    end
    $display("Sent %0d command words and checked %0d result words; %0d clears.",
             words_sent, words_checked, clears_sent);
    $display("The free list ran full with %0d rejected creates and wrapped around.", full_hits);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* entity_id_allocator.f */
hw/rtl/eia_pkg.sv
hw/rtl/eia_ram.sv
hw/rtl/entity_id_allocator.sv
tb/sv/tb_entity_id_allocator.sv
